>>> hdl/upscmc_pkg.sv
// Shared types and constants for the UPS charge mode controller.
// Holds the mode codes, register indexes, register reset values and widths.
// No dependencies.
package upscmc_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int AVG_DEPTH = 8;
    localparam int AVG_SHIFT = $clog2(AVG_DEPTH);
    localparam int SUM_W     = SAMPLE_W + AVG_SHIFT;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_TRICKLE   = 2'd1,
        MODE_DISCHARGE = 2'd2,
        MODE_CHARGE    = 2'd3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_CHARGE_CUTOFF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_DISCH_CUT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAINS_THRESHOLD  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRICKLE_MARGIN   = 2'd3;

    localparam logic [SAMPLE_W-1:0] RST_CHARGE_CUTOFF   = 16'd8200;
    localparam logic [SAMPLE_W-1:0] RST_IDLE_DISCH_CUT  = 16'd7700;
    localparam logic [SAMPLE_W-1:0] RST_MAINS_THRESHOLD = 16'd11900;
    localparam logic [SAMPLE_W-1:0] RST_TRICKLE_MARGIN  = 16'd100;

    typedef struct packed {
        logic [SAMPLE_W-1:0] battery_mean;
        logic [SAMPLE_W-1:0] main_mean;
    } t_means;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> hdl/upscmc_front.sv
// Front end: accepts sample pairs and keeps both moving-average histories.
// Produces the new means for the queue. Depends on upscmc_pkg.
module upscmc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [upscmc_pkg::SAMPLE_W-1:0] i_main_sample,
    input  logic [upscmc_pkg::SAMPLE_W-1:0] i_battery_sample,
    input  upscmc_pkg::t_q_status          i_q_status,
    output logic                           o_push,
    output upscmc_pkg::t_means             o_push_data
);
    import upscmc_pkg::*;

    logic [SAMPLE_W-1:0] r_main_hist [AVG_DEPTH];
    logic [SAMPLE_W-1:0] r_batt_hist [AVG_DEPTH];
    logic [SUM_W-1:0]    r_main_sum;
    logic [SUM_W-1:0]    r_batt_sum;
    logic [SUM_W-1:0]    n_main_sum;
    logic [SUM_W-1:0]    n_batt_sum;
    logic                accept;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;

    // running sum: add the new sample, drop the oldest
    assign n_main_sum = r_main_sum + SUM_W'(i_main_sample)
                        - SUM_W'(r_main_hist[AVG_DEPTH-1]);
    assign n_batt_sum = r_batt_sum + SUM_W'(i_battery_sample)
                        - SUM_W'(r_batt_hist[AVG_DEPTH-1]);

    assign o_push                   = accept;
    assign o_push_data.main_mean    = n_main_sum[SUM_W-1:AVG_SHIFT];
    assign o_push_data.battery_mean = n_batt_sum[SUM_W-1:AVG_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_sum <= '0;
            r_batt_sum <= '0;
            for (int k = 0; k < AVG_DEPTH; k++) begin
                r_main_hist[k] <= '0;
                r_batt_hist[k] <= '0;
            end
        end else if (accept) begin
            r_main_sum     <= n_main_sum;
            r_batt_sum     <= n_batt_sum;
            r_main_hist[0] <= i_main_sample;
            r_batt_hist[0] <= i_battery_sample;
            for (int k = 1; k < AVG_DEPTH; k++) begin
                r_main_hist[k] <= r_main_hist[k-1];
                r_batt_hist[k] <= r_batt_hist[k-1];
            end
        end
    end

endmodule

>>> hdl/upscmc_queue.sv
// Short queue of mean pairs between the front end and the mode machine.
// Depends on upscmc_pkg.
module upscmc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  upscmc_pkg::t_means    i_push_data,
    input  logic                  i_pop,
    output upscmc_pkg::t_means    o_pop_data,
    output upscmc_pkg::t_q_status o_status
);
    import upscmc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_means             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_pop_data     = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/upscmc_back.sv
// Back end: configuration registers, charger mode machine and output register.
// Pops mean pairs from the queue. Depends on upscmc_pkg.
module upscmc_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [upscmc_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [upscmc_pkg::SAMPLE_W-1:0]  i_cfg_wdata,
    input  upscmc_pkg::t_q_status            i_q_status,
    input  upscmc_pkg::t_means               i_pop_data,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output upscmc_pkg::t_mode                o_mode,
    output logic                             o_charge_enable,
    output logic                             o_trickle_enable,
    output logic [upscmc_pkg::SAMPLE_W-1:0]  o_main_mean,
    output logic [upscmc_pkg::SAMPLE_W-1:0]  o_battery_mean
);
    import upscmc_pkg::*;

    logic [SAMPLE_W-1:0] r_charge_cutoff;
    logic [SAMPLE_W-1:0] r_idle_disch_cut;
    logic [SAMPLE_W-1:0] r_mains_threshold;
    logic [SAMPLE_W-1:0] r_trickle_margin;
    t_mode               r_mode;
    t_mode               n_mode;
    logic                r_valid;
    logic [SAMPLE_W-1:0] r_main_mean;
    logic [SAMPLE_W-1:0] r_battery_mean;
    logic [SAMPLE_W-1:0] trickle_level;
    logic                mains_low;
    logic                mains_high;
    logic                batt_low;
    logic                batt_high;

    // take the next entry when the output slot is free or drains this cycle
    assign o_pop = !i_q_status.empty && (!r_valid || i_ready);

    assign trickle_level = (r_charge_cutoff > r_trickle_margin) ?
                           (r_charge_cutoff - r_trickle_margin) : '0;
    assign mains_low  = i_pop_data.main_mean < r_mains_threshold;
    assign mains_high = i_pop_data.main_mean > r_mains_threshold;
    assign batt_low   = i_pop_data.battery_mean < r_idle_disch_cut;
    assign batt_high  = i_pop_data.battery_mean > r_charge_cutoff;

    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_IDLE: begin
                if (mains_low) n_mode = MODE_DISCHARGE;
                else if (batt_low) n_mode = MODE_CHARGE;
                else if (i_pop_data.battery_mean < trickle_level) n_mode = MODE_TRICKLE;
            end
            MODE_TRICKLE: begin
                if (mains_low) n_mode = MODE_DISCHARGE;
                else if (batt_low) n_mode = MODE_CHARGE;
                else if (batt_high) n_mode = MODE_IDLE;
            end
            MODE_DISCHARGE: begin
                if (mains_high) n_mode = MODE_IDLE;
            end
            MODE_CHARGE: begin
                if (mains_low) n_mode = MODE_DISCHARGE;
                else if (batt_high) n_mode = MODE_IDLE;
            end
            default: n_mode = MODE_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge_cutoff   <= RST_CHARGE_CUTOFF;
            r_idle_disch_cut  <= RST_IDLE_DISCH_CUT;
            r_mains_threshold <= RST_MAINS_THRESHOLD;
            r_trickle_margin  <= RST_TRICKLE_MARGIN;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CHARGE_CUTOFF:   r_charge_cutoff   <= i_cfg_wdata;
                CFG_IDLE_DISCH_CUT:  r_idle_disch_cut  <= i_cfg_wdata;
                CFG_MAINS_THRESHOLD: r_mains_threshold <= i_cfg_wdata;
                CFG_TRICKLE_MARGIN:  r_trickle_margin  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode  <= n_mode;
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_main_mean    <= i_pop_data.main_mean;
            r_battery_mean <= i_pop_data.battery_mean;
        end
    end

    assign o_valid          = r_valid;
    assign o_mode           = r_mode;
    assign o_charge_enable  = (r_mode == MODE_CHARGE);
    assign o_trickle_enable = (r_mode == MODE_TRICKLE);
    assign o_main_mean      = r_main_mean;
    assign o_battery_mean   = r_battery_mean;

endmodule

>>> hdl/ups_charge_mode_controller_unit.sv
// UPS charge mode controller, top level.
// Instantiates front end, queue and back end; depends on upscmc_pkg.
//
// Usage:
//   Slave stream s_axis carries one sample pair per beat (main and battery).
//   Master stream m_axis returns one beat per input beat: new mode, charge
//   and trickle enables, and both 8-sample moving averages.
//   The config port writes a 16-bit register whenever i_cfg_we is high;
//   write only while no beat is in flight.
// Path: each input beat passes the queue, then the output register, to the output.
// Throughput: one beat per cycle while m_axis_tready is high. The front end updates
//   a running sum per channel; the mode machine pops one mean pair per cycle.
// Stall: when m_axis_tready is low the result holds in the output register,
//   further mean pairs collect in the queue (QUEUE_DEPTH entries), and
//   s_axis_tready drops once the queue is full.
// Reset: histories and sums clear to zero, mode returns to idle, registers
//   take their reset values, queue and output empty. No clearing sweep.
module ups_charge_mode_controller_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] main_sample, [31:16] battery_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] mode, [2] charge_enable, [3] trickle_enable,
    // [19:4] main_mean, [35:20] battery_mean, [39:36] zero
    output logic [39:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [upscmc_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [upscmc_pkg::SAMPLE_W-1:0]  i_cfg_wdata
);
    import upscmc_pkg::*;

    t_q_status           q_status;
    t_means              push_data;
    t_means              pop_data;
    logic                push;
    logic                pop;
    t_mode               mode;
    logic                charge_en;
    logic                trickle_en;
    logic [SAMPLE_W-1:0] main_mean;
    logic [SAMPLE_W-1:0] battery_mean;

    upscmc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_main_sample    (s_axis_tdata[15:0]),
        .i_battery_sample (s_axis_tdata[31:16]),
        .i_q_status       (q_status),
        .o_push           (push),
        .o_push_data      (push_data)
    );

    upscmc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_status    (q_status)
    );

    upscmc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_addr       (i_cfg_addr),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_q_status       (q_status),
        .i_pop_data       (pop_data),
        .o_pop            (pop),
        .o_valid          (m_axis_tvalid),
        .i_ready          (m_axis_tready),
        .o_mode           (mode),
        .o_charge_enable  (charge_en),
        .o_trickle_enable (trickle_en),
        .o_main_mean      (main_mean),
        .o_battery_mean   (battery_mean)
    );

    assign m_axis_tdata = {4'b0000, battery_mean, main_mean, trickle_en, charge_en, mode};

endmodule

>>> hdl/upscmc_checker.sv
// Port-level checker for the UPS charge mode controller, bound to the top.
// Depends on upscmc_pkg and ups_charge_mode_controller_unit.
module upscmc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    import upscmc_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat shown right after reset");

    a_charge_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2] == (m_axis_tdata[1:0] == MODE_CHARGE)))
        else $error("charge enable disagrees with mode");

    a_trickle_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3] == (m_axis_tdata[1:0] == MODE_TRICKLE)))
        else $error("trickle enable disagrees with mode");

    // with an idle output, an input beat passes queue and output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##1 m_axis_tvalid)
        else $error("result beat missing after accepted input");

endmodule

bind ups_charge_mode_controller_unit upscmc_checker u_upscmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
